[hw/rtl/assert_macros.svh]
// Assertion helpers for the checker file kslv_checker.sv.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSLV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KSLV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/kslv_pkg.sv]
`default_nettype none

package kslv_pkg;

  localparam int CODE_MAX_LEN   = 8;
  localparam int TIME_BITS      = 32;
  localparam int NUM_BUTTONS    = 5;
  localparam int SELECT_BIT     = 4;
  localparam int CODE_SLOTS     = 8;
  localparam int SYM_W          = 3;
  localparam int LEVELS_W       = 5;
  localparam int NOW_W          = 32;
  localparam int SYMBOLS_W      = 24;
  localparam int LENGTH_W       = 4;
  localparam int DEBOUNCE_W     = 16;
  localparam int COUNT_OUT_W    = 4;
  localparam int CFG_INDEX_W    = 2;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd200;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CODE_SYMBOLS = 2'd0,
    CFG_CODE_LENGTH  = 2'd1,
    CFG_DEBOUNCE_MS  = 2'd2
  } cfg_reg_t;

  typedef enum logic [SYM_W-1:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_t;

  // Debounced press events of one poll.
  typedef struct packed {
    logic sel;
    dir_t dir;
  } press_t;

  // One result item.
  typedef struct packed {
    logic                   unlocked;
    logic                   wrong_code;
    logic [COUNT_OUT_W-1:0] entered_count;
    dir_t                   accepted_symbol;
  } result_t;

  // Stored symbol at a position; positions beyond the register read as zero.
  function automatic logic [SYM_W-1:0] stored_symbol(input logic [SYMBOLS_W-1:0] code,
                                                     input int pos);
    logic [SYM_W-1:0] sym;
    sym = '0;
    for (int j = 0; j < CODE_SLOTS; j++) begin
      if (j == pos) begin
        sym = code[SYM_W*j +: SYM_W];
      end
    end
    return sym;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/kslv_debounce.sv]
`default_nettype none

module kslv_debounce #(
  parameter int TIME_BITS = kslv_pkg::TIME_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                step,
  input  wire logic [kslv_pkg::LEVELS_W-1:0]       levels,
  input  wire logic [TIME_BITS-1:0]                now,
  input  wire logic [kslv_pkg::DEBOUNCE_W-1:0]     debounce_ms,
  output kslv_pkg::press_t                         press
);

  logic [kslv_pkg::LEVELS_W-1:0] last_levels_r;
  logic [kslv_pkg::LEVELS_W-1:0] last_levels_nxt;
  logic [TIME_BITS-1:0]          last_time_r   [kslv_pkg::NUM_BUTTONS];
  logic [TIME_BITS-1:0]          diff          [kslv_pkg::NUM_BUTTONS];
  logic [kslv_pkg::LEVELS_W-1:0] take;
  logic [kslv_pkg::LEVELS_W-1:0] rise;

  always_comb begin
    for (int b = 0; b < kslv_pkg::NUM_BUTTONS; b++) begin
      diff[b] = now - last_time_r[b];
      take[b] = step && (levels[b] != last_levels_r[b]) &&
                (diff[b] > TIME_BITS'(debounce_ms));
    end
    rise            = take & levels;
    last_levels_nxt = (last_levels_r & ~take) | (levels & take);

    // A later direction in the order up, down, left, right wins.
    press.sel = rise[kslv_pkg::SELECT_BIT];
    if (rise[3]) begin
      press.dir = kslv_pkg::DIR_RIGHT;
    end else if (rise[2]) begin
      press.dir = kslv_pkg::DIR_LEFT;
    end else if (rise[1]) begin
      press.dir = kslv_pkg::DIR_DOWN;
    end else if (rise[0]) begin
      press.dir = kslv_pkg::DIR_UP;
    end else begin
      press.dir = kslv_pkg::DIR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_levels_r <= '0;
      for (int b = 0; b < kslv_pkg::NUM_BUTTONS; b++) begin
        last_time_r[b] <= '0;
      end
    end else begin
      last_levels_r <= last_levels_nxt;
      for (int b = 0; b < kslv_pkg::NUM_BUTTONS; b++) begin
        if (take[b]) begin
          last_time_r[b] <= now;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/kslv_entry.sv]
`default_nettype none

module kslv_entry #(
  parameter int CODE_MAX_LEN = kslv_pkg::CODE_MAX_LEN
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               step,
  input  wire logic [kslv_pkg::SYMBOLS_W-1:0]     code_symbols,
  input  wire logic [kslv_pkg::LENGTH_W-1:0]      code_length,
  input  wire kslv_pkg::press_t                   press,
  output logic                                    active,
  output kslv_pkg::result_t                       result
);

  localparam int CNT_W = $clog2(CODE_MAX_LEN + 1);
  localparam int IDX_W = (CODE_MAX_LEN > 1) ? $clog2(CODE_MAX_LEN) : 1;

  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic [CNT_W-1:0]          count_app;
  logic [kslv_pkg::SYM_W-1:0] buf_r   [CODE_MAX_LEN];
  logic [kslv_pkg::SYM_W-1:0] view    [CODE_MAX_LEN];
  logic                      open_r;
  logic                      open_nxt;
  logic                      lock_off;
  logic                      append;
  logic                      len_ok;
  logic                      sym_ok;
  logic                      sel_hit;
  logic                      wrong;

  always_comb begin
    lock_off  = (code_length == '0);
    active    = step && !open_r && !lock_off;
    append    = active && (press.dir != kslv_pkg::DIR_NONE) &&
                (count_r < CNT_W'(CODE_MAX_LEN));
    count_app = count_r + CNT_W'(append);

    // Compare against the entry as it stands after this poll's append.
    len_ok = (32'(count_app) == 32'(code_length));
    sym_ok = 1'b1;
    for (int i = 0; i < CODE_MAX_LEN; i++) begin
      view[i] = (append && (count_r == CNT_W'(i))) ? press.dir : buf_r[i];
      if ((CNT_W'(i) < count_app) &&
          (view[i] != kslv_pkg::stored_symbol(code_symbols, i))) begin
        sym_ok = 1'b0;
      end
    end

    sel_hit   = active && press.sel;
    wrong     = sel_hit && !(len_ok && sym_ok);
    open_nxt  = open_r || (step && lock_off) || (sel_hit && len_ok && sym_ok);
    count_nxt = wrong ? '0 : count_app;

    result.unlocked        = open_nxt;
    result.wrong_code      = wrong;
    result.entered_count   = kslv_pkg::COUNT_OUT_W'(count_nxt);
    result.accepted_symbol = append ? press.dir : kslv_pkg::DIR_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      open_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      open_r  <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (append) begin
      buf_r[count_r[IDX_W-1:0]] <= press.dir;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/keypad_sequence_lock_verify.sv]
// Keypad sequence lock with per-button debounce.
// Input channel: one poll per transfer (in_button_levels, in_now_ms), taken at
// a rising edge with in_valid high and in_stall low. Result channel: one
// result per poll (out_unlocked, out_wrong_code, out_entered_count,
// out_accepted_symbol), taken at a rising edge with out_valid high and
// out_stall low. Configuration: cfg_index selects code symbols (0), code
// length (1) or debounce time (2); cfg_ready is always high, so a write lands
// at any edge with cfg_valid high. Write only while no poll is in flight.
// The poll is held in the input register, then the debouncers, entry update
// and eight-symbol compare run combinationally into the result register.
// Throughput is one poll per cycle while the result is not stalled.
// A stalled result holds; the input register keeps accepting while the
// result register can drain, and in_stall rises only when both are full.
// Reset (synchronous, rst_n low) releases all buttons, zeroes the debounce
// timestamps, empties the entry, relocks and sets the debounce time to 200.
// With code length zero every poll reports unlocked.
`default_nettype none

module keypad_sequence_lock_verify #(
  parameter int CODE_MAX_LEN = kslv_pkg::CODE_MAX_LEN,
  parameter int TIME_BITS    = kslv_pkg::TIME_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [kslv_pkg::LEVELS_W-1:0]       in_button_levels,
  input  wire logic [kslv_pkg::NOW_W-1:0]          in_now_ms,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_unlocked,
  output logic                                     out_wrong_code,
  output logic [kslv_pkg::COUNT_OUT_W-1:0]         out_entered_count,
  output logic [kslv_pkg::SYM_W-1:0]               out_accepted_symbol,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [kslv_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [kslv_pkg::SYMBOLS_W-1:0]      cfg_data
);

  logic                                 s1_valid_r;
  logic [kslv_pkg::LEVELS_W-1:0]        s1_levels_r;
  logic [kslv_pkg::NOW_W-1:0]           s1_now_r;
  logic [TIME_BITS+kslv_pkg::NOW_W-1:0] now_wide;
  logic [TIME_BITS-1:0]                 now_t;
  logic                                 advance;
  logic                                 in_take;
  logic                                 active;
  kslv_pkg::press_t                     press;
  kslv_pkg::result_t                    result;
  kslv_pkg::result_t                    out_r;
  logic                                 out_valid_r;
  logic [kslv_pkg::SYMBOLS_W-1:0]       code_symbols_r;
  logic [kslv_pkg::LENGTH_W-1:0]        code_length_r;
  logic [kslv_pkg::DEBOUNCE_W-1:0]      debounce_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_symbols_r <= '0;
      code_length_r  <= '0;
      debounce_r     <= kslv_pkg::DEBOUNCE_RESET;
    end else if (cfg_valid) begin
      case (kslv_pkg::cfg_reg_t'(cfg_index))
        kslv_pkg::CFG_CODE_SYMBOLS: code_symbols_r <= cfg_data;
        kslv_pkg::CFG_CODE_LENGTH:  code_length_r  <= cfg_data[kslv_pkg::LENGTH_W-1:0];
        kslv_pkg::CFG_DEBOUNCE_MS:  debounce_r     <= cfg_data[kslv_pkg::DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  // The held poll moves on whenever the result register is empty or draining.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_levels_r <= in_button_levels;
      s1_now_r    <= in_now_ms;
    end
  end

  assign now_wide = {{TIME_BITS{1'b0}}, s1_now_r};
  assign now_t    = now_wide[TIME_BITS-1:0];

  kslv_debounce #(
    .TIME_BITS (TIME_BITS)
  ) u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (active),
    .levels      (s1_levels_r),
    .now         (now_t),
    .debounce_ms (debounce_r),
    .press       (press)
  );

  kslv_entry #(
    .CODE_MAX_LEN (CODE_MAX_LEN)
  ) u_entry (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .code_symbols (code_symbols_r),
    .code_length  (code_length_r),
    .press        (press),
    .active       (active),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_unlocked        = out_r.unlocked;
  assign out_wrong_code      = out_r.wrong_code;
  assign out_entered_count   = out_r.entered_count;
  assign out_accepted_symbol = out_r.accepted_symbol;

endmodule

`default_nettype wire

[hw/rtl/kslv_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module kslv_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic                               out_unlocked,
  input wire logic                               out_wrong_code,
  input wire logic [kslv_pkg::COUNT_OUT_W-1:0]   out_entered_count,
  input wire logic [kslv_pkg::SYM_W-1:0]         out_accepted_symbol
);

  localparam int BUS_W = 2 + kslv_pkg::COUNT_OUT_W + kslv_pkg::SYM_W;

  logic             seen_unlocked_r;
  logic             held_open;
  logic             frozen_ok;
  logic             wrong_out;
  logic             stalled;
  logic [BUS_W-1:0] out_bus;

  // Once a transfer has shown the lock open, it stays open until reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_unlocked_r <= 1'b0;
    end else if (out_valid && !out_stall && out_unlocked) begin
      seen_unlocked_r <= 1'b1;
    end
  end

  // The poll that opens the lock may still append a symbol; later polls are ignored.
  assign held_open = out_valid && seen_unlocked_r;
  assign frozen_ok = !out_wrong_code && (out_accepted_symbol == kslv_pkg::DIR_NONE);
  assign wrong_out = out_valid && out_wrong_code;
  assign stalled   = out_valid && out_stall;
  assign out_bus   = {out_unlocked, out_wrong_code, out_entered_count, out_accepted_symbol};

  `KSLV_ASSERT_NOW(a_open_sticky, held_open, out_unlocked, "lock relocked without reset")

  `KSLV_ASSERT_NOW(a_open_quiet, held_open, frozen_ok, "open lock still took input")

  `KSLV_ASSERT_NOW(a_wrong_clears, wrong_out, out_entered_count == '0, "entry left uncleared")

  `KSLV_ASSERT_NEXT(a_stall_hold, stalled, out_valid && $stable(out_bus), "stalled result changed")

endmodule

bind keypad_sequence_lock_verify kslv_checker u_kslv_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_unlocked        (out_unlocked),
  .out_wrong_code      (out_wrong_code),
  .out_entered_count   (out_entered_count),
  .out_accepted_symbol (out_accepted_symbol)
);

`default_nettype wire
